FILE: rtl/buddy_block_allocator_top_macros.svh
// ---------------------------------------------------------------------------
// buddy block allocator assertion macros
// concurrent checks clocked on clk, disabled during reset
// ---------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/bba_pkg.sv
// ---------------------------------------------------------------------------
// bba_pkg
// shared constants, codes and types of the buddy block allocator
// ---------------------------------------------------------------------------
package bba_pkg;
	localparam int PAGE_ORDER_DEF = 12;
	localparam int POOL_ORDER_DEF = 20;

	localparam int CMD_W  = 1;
	localparam int REQ_W  = 21;
	localparam int OFF_W  = 20;
	localparam int STAT_W = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FAIL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD_FREE = 2'd2;

	typedef struct packed {
		logic en;
		logic we;
	} mem_op_t;
endpackage

FILE: rtl/bba_if.sv
// ---------------------------------------------------------------------------
// bba_if
// request and response channels of the buddy block allocator
// ---------------------------------------------------------------------------
interface bba_req_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::CMD_W-1:0]   cmd;
	logic [bba_pkg::REQ_W-1:0]   req_bytes;
	logic [bba_pkg::OFF_W-1:0]   block_offset;
	modport source (output valid, cmd, req_bytes, block_offset, input ready);
	modport sink   (input valid, cmd, req_bytes, block_offset, output ready);
endinterface

interface bba_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bba_pkg::STAT_W-1:0]  status;
	logic [bba_pkg::OFF_W-1:0]   granted_offset;
	modport source (output valid, status, granted_offset, input ready);
	modport sink   (input valid, status, granted_offset, output ready);
endinterface

FILE: rtl/bba_page_ram.sv
// ---------------------------------------------------------------------------
// bba_page_ram
// single port page table memory, registered read
// ---------------------------------------------------------------------------
module bba_page_ram #(
	parameter int AW = 8,
	parameter int DW = 24
) (
	input  logic             clk,
	input  bba_pkg::mem_op_t op,
	input  logic [AW-1:0]    addr,
	input  logic [DW-1:0]    wdata,
	output logic [DW-1:0]    rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (op.en && op.we) begin
			mem[addr] <= wdata;
		end
		if (op.en && !op.we) begin
			rdata <= mem[addr];
		end
	end
endmodule

FILE: rtl/bba_ctrl.sv
// ---------------------------------------------------------------------------
// bba_ctrl
// sequencer: table clear, size rounding, list search, split and merge over the page table
// ---------------------------------------------------------------------------
`include "buddy_block_allocator_top_macros.svh"

module bba_ctrl #(
	parameter int PAGE_ORDER = bba_pkg::PAGE_ORDER_DEF,
	parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF,
	parameter int DW = 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	bba_req_if.sink                 req,
	bba_rsp_if.source               rsp,
	output bba_pkg::mem_op_t        mem_op,
	output logic [POOL_ORDER-PAGE_ORDER-1:0] mem_addr,
	output logic [DW-1:0]           mem_wdata,
	input  logic [DW-1:0]           mem_rdata
);
	localparam int PGW  = POOL_ORDER - PAGE_ORDER;
	localparam int PW   = PGW + 1;
	localparam int OW   = $clog2(PGW + 1);
	localparam int NORD = PGW + 1;
	localparam int LW   = (POOL_ORDER + 1 > bba_pkg::REQ_W) ? POOL_ORDER + 1 : bba_pkg::REQ_W;
	localparam int CW   = (PW > bba_pkg::OFF_W) ? PW : bba_pkg::OFF_W;
	localparam int GW   = (POOL_ORDER > bba_pkg::OFF_W) ? POOL_ORDER : bba_pkg::OFF_W;

	localparam logic [PW-1:0] NULLP = {1'b1, {PGW{1'b0}}};
	localparam logic [OW-1:0] TOPK  = OW'(PGW);

	typedef struct packed {
		logic [PW-1:0] nxt;
		logic [PW-1:0] prv;
		logic [OW-1:0] ord;
		logic          onf;
		logic          alc;
	} ent_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_A_NEED, S_A_SRCH, S_A_UNL, S_A_NP, S_A_SPL,
		S_P_WR, S_P_HRD, S_P_HWR,
		S_F_CHK, S_F_MRG, S_F_BCHK, S_F_PRD, S_F_PWR, S_F_N, S_F_NWR, S_F_ADV,
		S_FIN
	} state_t;

	state_t                     state_q;
	logic [PGW-1:0]             clr_q;
	logic [PW-1:0]              head_q [NORD];
	logic [PGW-1:0]             p_q, b_q;
	logic [PW-1:0]              h_q, n_q, pr_q;
	logic [OW-1:0]              k_q, need_q;
	logic [LW-1:0]              lim_q, req_q;
	logic [bba_pkg::CMD_W-1:0]  op_q;
	logic [bba_pkg::STAT_W-1:0] st_q, out_st_q;
	logic [bba_pkg::OFF_W-1:0]  off_q, out_off_q;
	logic                       out_v_q;

	ent_t           ent_rd, ent_top, ent_zero, ent_wr;
	logic [PW-1:0]  hk;
	logic [OW-1:0]  kd;
	logic [PGW-1:0] bit_k, bit_kd, in_page;
	logic [CW-1:0]  in_shift;
	logic           in_bad, accept, out_free, match;
	logic [GW-1:0]  grant_w;

	assign ent_rd   = ent_t'(mem_rdata);
	assign ent_top  = '{nxt: NULLP, prv: NULLP, ord: TOPK, onf: 1'b1, alc: 1'b0};
	assign ent_zero = '{nxt: NULLP, prv: NULLP, ord: '0, onf: 1'b0, alc: 1'b0};
	assign hk       = head_q[k_q];
	assign kd       = k_q - OW'(1);
	assign bit_k    = PGW'(1) << k_q;
	assign bit_kd   = PGW'(1) << kd;
	assign in_shift = CW'(req.block_offset) >> PAGE_ORDER;
	assign in_bad   = in_shift >= CW'(NULLP);
	assign in_page  = in_shift[PGW-1:0];
	assign accept   = req.valid && req.ready;
	assign out_free = !out_v_q || rsp.ready;
	assign match    = ent_rd.onf && (ent_rd.ord == k_q);
	assign grant_w  = GW'(p_q) << PAGE_ORDER;

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_v_q;
	assign rsp.status         = out_st_q;
	assign rsp.granted_offset = out_off_q;
	assign mem_wdata          = DW'(ent_wr);

	always_comb begin
		mem_op   = '{en: 1'b0, we: 1'b0};
		mem_addr = p_q;
		ent_wr   = ent_rd;
		case (state_q)
			S_CLR: begin
				mem_op   = '{en: 1'b1, we: 1'b1};
				mem_addr = clr_q;
				ent_wr   = (clr_q == '0) ? ent_top : ent_zero;
			end
			S_IDLE: begin
				if (accept && req.cmd == bba_pkg::CMD_FREE && !in_bad) begin
					mem_op   = '{en: 1'b1, we: 1'b0};
					mem_addr = in_page;
				end
			end
			S_A_SRCH: begin
				if (hk != NULLP) begin
					mem_op   = '{en: 1'b1, we: 1'b0};
					mem_addr = hk[PGW-1:0];
				end
			end
			S_A_UNL: begin
				if (ent_rd.nxt != NULLP) begin
					mem_op   = '{en: 1'b1, we: 1'b0};
					mem_addr = ent_rd.nxt[PGW-1:0];
				end
			end
			S_A_NP: begin
				mem_op     = '{en: 1'b1, we: 1'b1};
				mem_addr   = n_q[PGW-1:0];
				ent_wr.prv = NULLP;
			end
			S_A_SPL: begin
				if (k_q == need_q) begin
					mem_op   = '{en: 1'b1, we: 1'b1};
					mem_addr = p_q;
					ent_wr   = '{nxt: NULLP, prv: NULLP, ord: need_q, onf: 1'b0, alc: 1'b1};
				end else begin
					mem_op   = '{en: 1'b1, we: 1'b0};
					mem_addr = p_q ^ bit_kd;
				end
			end
			S_P_WR: begin
				mem_op   = '{en: 1'b1, we: 1'b1};
				mem_addr = b_q;
				ent_wr   = '{nxt: hk, prv: NULLP, ord: k_q, onf: 1'b1, alc: ent_rd.alc};
			end
			S_P_HRD: begin
				mem_op   = '{en: 1'b1, we: 1'b0};
				mem_addr = h_q[PGW-1:0];
			end
			S_P_HWR: begin
				mem_op     = '{en: 1'b1, we: 1'b1};
				mem_addr   = h_q[PGW-1:0];
				ent_wr.prv = {1'b0, b_q};
			end
			S_F_CHK: begin
				if (ent_rd.alc) begin
					mem_op     = '{en: 1'b1, we: 1'b1};
					mem_addr   = p_q;
					ent_wr.alc = 1'b0;
				end
			end
			S_F_MRG: begin
				mem_op   = '{en: 1'b1, we: 1'b0};
				mem_addr = (k_q == TOPK) ? p_q : (p_q ^ bit_k);
			end
			S_F_BCHK: begin
				if (match) begin
					mem_op     = '{en: 1'b1, we: 1'b1};
					mem_addr   = b_q;
					ent_wr.nxt = NULLP;
					ent_wr.prv = NULLP;
					ent_wr.onf = 1'b0;
				end else begin
					mem_op   = '{en: 1'b1, we: 1'b0};
					mem_addr = p_q;
				end
			end
			S_F_PRD: begin
				mem_op   = '{en: 1'b1, we: 1'b0};
				mem_addr = pr_q[PGW-1:0];
			end
			S_F_PWR: begin
				mem_op     = '{en: 1'b1, we: 1'b1};
				mem_addr   = pr_q[PGW-1:0];
				ent_wr.nxt = n_q;
			end
			S_F_N: begin
				if (n_q != NULLP) begin
					mem_op   = '{en: 1'b1, we: 1'b0};
					mem_addr = n_q[PGW-1:0];
				end
			end
			S_F_NWR: begin
				mem_op     = '{en: 1'b1, we: 1'b1};
				mem_addr   = n_q[PGW-1:0];
				ent_wr.prv = pr_q;
			end
			default: begin
				mem_op = '{en: 1'b0, we: 1'b0};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < NORD; i++) begin
				head_q[i] <= (i == PGW) ? '0 : NULLP;
			end
		end else begin
			if (out_v_q && rsp.ready && state_q != S_FIN) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + PGW'(1);
					if (clr_q == {PGW{1'b1}}) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q   <= req.cmd;
						req_q  <= LW'(req.req_bytes);
						need_q <= '0;
						lim_q  <= LW'(1) << PAGE_ORDER;
						p_q    <= in_page;
						off_q  <= '0;
						if (req.cmd == bba_pkg::CMD_ALLOC) begin
							state_q <= S_A_NEED;
						end else if (in_bad) begin
							st_q    <= bba_pkg::ST_BAD_FREE;
							state_q <= S_FIN;
						end else begin
							state_q <= S_F_CHK;
						end
					end
				end
				S_A_NEED: begin
					if (req_q <= lim_q) begin
						k_q     <= need_q;
						state_q <= S_A_SRCH;
					end else if (need_q == TOPK) begin
						st_q    <= bba_pkg::ST_FAIL;
						state_q <= S_FIN;
					end else begin
						need_q <= need_q + OW'(1);
						lim_q  <= lim_q << 1;
					end
				end
				S_A_SRCH: begin
					if (hk != NULLP) begin
						p_q     <= hk[PGW-1:0];
						state_q <= S_A_UNL;
					end else if (k_q == TOPK) begin
						st_q    <= bba_pkg::ST_FAIL;
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + OW'(1);
					end
				end
				S_A_UNL: begin
					head_q[k_q] <= ent_rd.nxt;
					n_q         <= ent_rd.nxt;
					state_q     <= (ent_rd.nxt != NULLP) ? S_A_NP : S_A_SPL;
				end
				S_A_NP: begin
					state_q <= S_A_SPL;
				end
				S_A_SPL: begin
					if (k_q == need_q) begin
						st_q    <= bba_pkg::ST_OK;
						off_q   <= grant_w[bba_pkg::OFF_W-1:0];
						state_q <= S_FIN;
					end else begin
						k_q     <= kd;
						b_q     <= p_q ^ bit_kd;
						state_q <= S_P_WR;
					end
				end
				S_P_WR: begin
					head_q[k_q] <= {1'b0, b_q};
					h_q         <= hk;
					if (hk != NULLP) begin
						state_q <= S_P_HRD;
					end else if (op_q == bba_pkg::CMD_ALLOC) begin
						state_q <= S_A_SPL;
					end else begin
						st_q    <= bba_pkg::ST_OK;
						state_q <= S_FIN;
					end
				end
				S_P_HRD: begin
					state_q <= S_P_HWR;
				end
				S_P_HWR: begin
					if (op_q == bba_pkg::CMD_ALLOC) begin
						state_q <= S_A_SPL;
					end else begin
						st_q    <= bba_pkg::ST_OK;
						state_q <= S_FIN;
					end
				end
				S_F_CHK: begin
					if (!ent_rd.alc) begin
						st_q    <= bba_pkg::ST_BAD_FREE;
						state_q <= S_FIN;
					end else begin
						k_q     <= ent_rd.ord;
						state_q <= S_F_MRG;
					end
				end
				S_F_MRG: begin
					if (k_q == TOPK) begin
						b_q     <= p_q;
						state_q <= S_P_WR;
					end else begin
						b_q     <= p_q ^ bit_k;
						state_q <= S_F_BCHK;
					end
				end
				S_F_BCHK: begin
					if (match) begin
						n_q  <= ent_rd.nxt;
						pr_q <= ent_rd.prv;
						if (ent_rd.prv == NULLP) begin
							head_q[k_q] <= ent_rd.nxt;
							state_q     <= S_F_N;
						end else begin
							state_q <= S_F_PRD;
						end
					end else begin
						b_q     <= p_q;
						state_q <= S_P_WR;
					end
				end
				S_F_PRD: begin
					state_q <= S_F_PWR;
				end
				S_F_PWR: begin
					state_q <= S_F_N;
				end
				S_F_N: begin
					state_q <= (n_q != NULLP) ? S_F_NWR : S_F_ADV;
				end
				S_F_NWR: begin
					state_q <= S_F_ADV;
				end
				S_F_ADV: begin
					if (b_q < p_q) begin
						p_q <= b_q;
					end
					k_q     <= k_q + OW'(1);
					state_q <= S_F_MRG;
				end
				S_FIN: begin
					if (out_free) begin
						out_v_q   <= 1'b1;
						out_st_q  <= st_q;
						out_off_q <= (st_q == bba_pkg::ST_OK) ? off_q : '0;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BBA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != S_IDLE, "accepted word left block idle")
	`BBA_ASSERT(a_out_load_from_fin, $rose(out_v_q) |-> $past(state_q == S_FIN), "response without finish")
	`BBA_ASSERT(a_grant_zero, out_v_q |-> (out_st_q == bba_pkg::ST_OK || out_off_q == '0), "offset on failed word")
endmodule

FILE: rtl/buddy_block_allocator_top.sv
// ---------------------------------------------------------------------------
// buddy_block_allocator_top
// buddy allocator over a pool of pages, per-page state held in one page table memory,
// free-list heads held in registers
// channel  dir  fields
// req      in   cmd, req_bytes, block_offset
// rsp      out  status, granted_offset
//
// one word in flight; the time per word is set by the single page table
// port, through which each split or merge step makes its memory reads and writes
// after reset a clearing pass over every page table entry runs first
// a finished word waits in the output register while the next word is taken
// ---------------------------------------------------------------------------
module buddy_block_allocator_top #(
	parameter int PAGE_ORDER = bba_pkg::PAGE_ORDER_DEF,
	parameter int POOL_ORDER = bba_pkg::POOL_ORDER_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	bba_req_if.sink   req,
	bba_rsp_if.source rsp
);
	localparam int AW = POOL_ORDER - PAGE_ORDER;
	localparam int DW = 2 * (AW + 1) + $clog2(AW + 1) + 2;

	bba_pkg::mem_op_t mem_op;
	logic [AW-1:0]    mem_addr;
	logic [DW-1:0]    mem_wdata, mem_rdata;

	bba_ctrl #(
		.PAGE_ORDER(PAGE_ORDER),
		.POOL_ORDER(POOL_ORDER),
		.DW(DW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.mem_op(mem_op),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.mem_rdata(mem_rdata)
	);

	bba_page_ram #(
		.AW(AW),
		.DW(DW)
	) u_ram (
		.clk(clk),
		.op(mem_op),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// buddy block allocator testbench
// drives directed and random allocate and free words, the random ones in bursts
// and gaps, predicts each response with a buddy free-list model and compares
// status and offset
module tb_top;
	import bba_pkg::*;

	localparam int NPG = 256;
	localparam int TOPK = 8;
	localparam int NULLP = NPG;
	localparam int WDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bba_req_if req_ch ();
	bba_rsp_if rsp_ch ();

	buddy_block_allocator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [OFF_W-1:0]  offset;
	} grant_t;

	int free_head [TOPK+1];
	int nxt [NPG];
	int prv [NPG];
	int blk_ord [NPG];
	bit on_list [NPG];
	bit in_use [NPG];
	int live_q [$];

	grant_t grant_q [$];
	int fail_cnt = 0;
	int n_alloc = 0;
	int n_free = 0;
	int n_fail = 0;
	int n_bad = 0;
	int n_rsp = 0;
	int idle_cyc = 0;
	bit hold_off = 1'b0;
	bit stall_on = 1'b0;

	task automatic push_blk(input int p, input int k);
		nxt[p] = free_head[k];
		prv[p] = NULLP;
		if (free_head[k] != NULLP)
			prv[free_head[k]] = p;
		free_head[k] = p;
		blk_ord[p] = k;
		on_list[p] = 1'b1;
	endtask

	task automatic unlink_blk(input int p, input int k);
		int n;
		int pr;
		n = nxt[p];
		pr = prv[p];
		if (pr == NULLP)
			free_head[k] = n;
		else
			nxt[pr] = n;
		if (n != NULLP)
			prv[n] = pr;
		nxt[p] = NULLP;
		prv[p] = NULLP;
		on_list[p] = 1'b0;
	endtask

	task automatic pool_reset();
		for (int i = 0; i <= TOPK; i++)
			free_head[i] = NULLP;
		for (int i = 0; i < NPG; i++) begin
			nxt[i] = NULLP;
			prv[i] = NULLP;
			blk_ord[i] = 0;
			on_list[i] = 1'b0;
			in_use[i] = 1'b0;
		end
		live_q.delete();
		push_blk(0, TOPK);
	endtask

	task automatic predict_grant(input logic [CMD_W-1:0] c, input logic [REQ_W-1:0] rb,
			input logic [OFF_W-1:0] off, output grant_t g);
		int need;
		int k;
		int p;
		int b;
		bit done;
		g = '0;
		if (c == CMD_ALLOC) begin
			n_alloc++;
			need = 0;
			while (need <= TOPK && (longint'(1) << (need + 12)) < longint'(rb))
				need++;
			g.status = ST_FAIL;
			done = 1'b0;
			if (need <= TOPK) begin
				for (k = need; k <= TOPK && !done; k++) begin
					if (free_head[k] != NULLP) begin
						p = free_head[k];
						unlink_blk(p, k);
						for (int j = k - 1; j >= need; j--)
							push_blk(p ^ (1 << j), j);
						blk_ord[p] = need;
						in_use[p] = 1'b1;
						live_q.push_back(p);
						g.status = ST_OK;
						g.offset = OFF_W'(p << 12);
						done = 1'b1;
					end
				end
			end
			if (!done)
				n_fail++;
		end else begin
			n_free++;
			p = int'(off >> 12);
			if (!in_use[p]) begin
				g.status = ST_BAD_FREE;
				n_bad++;
			end else begin
				in_use[p] = 1'b0;
				foreach (live_q[i])
					if (live_q[i] == p) begin
						live_q.delete(i);
						break;
					end
				k = blk_ord[p];
				while (k < TOPK) begin
					b = p ^ (1 << k);
					if (!on_list[b] || blk_ord[b] != k)
						break;
					unlink_blk(b, k);
					if (b < p)
						p = b;
					k++;
				end
				push_blk(p, k);
				g.status = ST_OK;
			end
		end
	endtask

	task automatic send_word(input logic [CMD_W-1:0] c, input logic [REQ_W-1:0] rb,
			input logic [OFF_W-1:0] off);
		grant_t g;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.req_bytes <= rb;
		req_ch.block_offset <= off;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predict_grant(c, rb, off, g);
		grant_q.push_back(g);
		@(negedge clk);
	endtask

	task automatic send_gap();
		req_ch.valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	task automatic free_random_live();
		int i;
		i = $urandom_range(0, live_q.size() - 1);
		send_word(CMD_FREE, REQ_W'($urandom), OFF_W'((live_q[i] << 12) | $urandom_range(0, 4095)));
	endtask

	task automatic test_directed();
		send_word(CMD_ALLOC, 21'd0, 20'd0);
		send_word(CMD_ALLOC, 21'd1, 20'hFFFFF);
		send_word(CMD_ALLOC, 21'd4096, 20'd0);
		send_word(CMD_ALLOC, 21'd4097, 20'd0);
		send_word(CMD_ALLOC, 21'h1FFFFF, 20'd0);
		send_word(CMD_ALLOC, 21'h100001, 20'd0);
		send_word(CMD_FREE, 21'h1FFFFF, 20'h01000);
		send_word(CMD_FREE, 21'd0, 20'h01000);
		send_word(CMD_FREE, 21'd0, 20'hFFFFF);
		send_word(CMD_FREE, 21'd0, 20'h00FFF);
		send_word(CMD_FREE, 21'd0, 20'h02000);
		send_word(CMD_FREE, 21'd0, 20'h04000);
		send_word(CMD_ALLOC, 21'h100000, 20'd0);
		send_word(CMD_ALLOC, 21'd1, 20'd0);
		send_word(CMD_FREE, 21'd0, 20'h00000);
		send_word(CMD_FREE, 21'd0, 20'h00000);
		send_word(CMD_ALLOC, 21'h080000, 20'd0);
		send_word(CMD_ALLOC, 21'h080000, 20'd0);
		send_word(CMD_ALLOC, 21'd1, 20'd0);
		send_word(CMD_FREE, 21'd0, 20'h80000);
		send_word(CMD_FREE, 21'd0, 20'h00000);
		send_gap();
	endtask

	task automatic test_random();
		int burst;
		int r;
		for (int n = 0; n < 1800; ) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst; j++, n++) begin
				r = $urandom_range(0, 99);
				if (r < 45)
					send_word(CMD_ALLOC, ($urandom_range(0, 3) == 0) ?
						REQ_W'($urandom) : REQ_W'($urandom_range(0, 1 << $urandom_range(12, 17))),
						OFF_W'($urandom));
				else if (r < 88 && live_q.size() > 0)
					free_random_live();
				else
					send_word(CMD_FREE, REQ_W'($urandom), OFF_W'($urandom));
			end
			if ($urandom_range(0, 3) != 0)
				send_gap();
		end
		send_gap();
	endtask

	task automatic test_backpressure();
		hold_off = 1'b1;
		for (int i = 0; i < 8; i++)
			send_word(CMD_ALLOC, 21'd1, OFF_W'($urandom));
		send_gap();
		wait (!hold_off);
	endtask

	// receiver stall pattern and long hold-off
	always @(negedge clk) begin
		if (hold_off) begin
			rsp_ch.ready <= 1'b0;
			idle_cyc++;
			if (idle_cyc > 300) begin
				hold_off <= 1'b0;
				idle_cyc = 0;
			end
		end else begin
			if ($urandom_range(0, 31) == 0)
				stall_on <= !stall_on;
			rsp_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_rsp++;
			if (grant_q.size() == 0) begin
				$error("response with nothing outstanding");
				fail_cnt++;
			end else begin
				exp_g = grant_q.pop_front();
				if (rsp_ch.status !== exp_g.status) begin
					$error("status exp %0d got %0d", exp_g.status, rsp_ch.status);
					fail_cnt++;
				end
				if (rsp_ch.granted_offset !== exp_g.offset) begin
					$error("granted_offset exp %h got %h", exp_g.offset,
						rsp_ch.granted_offset);
					fail_cnt++;
				end
			end
		end
	end

	// watchdog
	int quiet = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet = 0;
		else if (++quiet >= WDOG_LIMIT) begin
			$display("buddy_block_allocator_top verification failed");
			$finish;
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_ALLOC;
		req_ch.req_bytes = '0;
		req_ch.block_offset = '0;
		rsp_ch.ready = 1'b0;
		pool_reset();
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random();
		while (grant_q.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		$display("sent %0d allocates (%0d failed) and %0d frees (%0d bad), %0d responses",
			n_alloc, n_fail, n_free, n_bad, n_rsp);
		if (fail_cnt == 0)
			$display("buddy_block_allocator_top verification clean");
		else
			$display("buddy_block_allocator_top verification failed");
		$finish;
	end
endmodule
